FILE: design/kl_pkg.sv
package kl_pkg;

    // Default sizes, handed down through the top level parameters
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_LEXEME_DEF  = 8;

    localparam int TEXT_W    = 64;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = 6;
    localparam int NUM_KW    = 5;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_IGNORE  = 8'hFF;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_WORD = 5'b00010,
        MODE_NUM  = 5'b00100,
        MODE_LT   = 5'b01000,
        MODE_EQ   = 5'b10000
    } t_mode;

    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_KEYWORD = 4'd1,
        KIND_NUMBER  = 4'd2,
        KIND_PLUS    = 4'd3,
        KIND_MINUS   = 4'd4,
        KIND_STAR    = 4'd5,
        KIND_LT      = 4'd6,
        KIND_LE      = 4'd7,
        KIND_EQ      = 4'd8,
        KIND_ASSIGN  = 4'd9,
        KIND_SEMI    = 4'd10,
        KIND_ILLEGAL = 4'd11
    } t_kind;

    // Keyword text packed first character in the low byte; index is the keyword code
    localparam logic [TEXT_W-1:0] KW_TXT [NUM_KW] = '{
        64'h0000_0065_6C69_6877,   // while
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_6863_7469_7773,   // switch
        64'h0000_0000_6573_6163    // case
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{4'd5, 4'd2, 4'd4, 4'd6, 4'd4};

    typedef struct packed {
        t_kind             kind;
        logic [2:0]        keyword_code;
        logic [IDX_W-1:0]  table_index;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  text_length;
        logic              truncated;
        logic              table_full;
        logic              last;
    } t_tok;

    typedef struct packed {
        t_mode            mode;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } t_scan_stat;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_kw_hit;

    // Parallel compare against all keywords; unused buffer bytes are zero
    function automatic t_kw_hit kw_lookup(input logic [TEXT_W-1:0] lex,
                                          input logic [LEN_W-1:0] len,
                                          input logic ovf);
        t_kw_hit res;
        res = '0;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (!ovf && len == KW_LEN[i] && lex == KW_TXT[i]) begin
                res.hit  = 1'b1;
                res.code = 3'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: design/kl_scan.sv
module kl_scan import kl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_LEXEME  = MAX_LEXEME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_ch,
    input  logic       i_eoi,
    output t_tok       o_tok_a,
    output t_tok       o_tok_b,
    output logic [1:0] o_push_n,
    output t_scan_stat o_stat
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_mode              r_mode, n_mode;
    logic [TEXT_W-1:0]  r_buf, n_buf;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_sym_cnt, n_sym_cnt;
    logic [CNT_W-1:0]   r_con_cnt, n_con_cnt;

    t_kw_hit kw;
    logic    sym_full, con_full;
    logic    do_flush, do_start, do_append;
    logic    has_f, has_s;
    t_tok    tok_f, tok_s, flush_tok;
    logic    is_lower, is_digit;

    assign kw       = kw_lookup(r_buf, r_len, r_ovf);
    assign sym_full = (r_sym_cnt == CNT_W'(TABLE_DEPTH));
    assign con_full = (r_con_cnt == CNT_W'(TABLE_DEPTH));
    assign is_lower = (i_ch >= CH_LOWER_A) && (i_ch <= CH_LOWER_Z);
    assign is_digit = (i_ch >= CH_DIGIT_0) && (i_ch <= CH_DIGIT_9);

    // token produced by flushing the pending lexeme or operator
    always_comb begin
        flush_tok = '0;
        case (r_mode)
            MODE_WORD: begin
                flush_tok.text        = r_buf;
                flush_tok.text_length = r_len;
                if (kw.hit) begin
                    flush_tok.kind         = KIND_KEYWORD;
                    flush_tok.keyword_code = kw.code;
                end else begin
                    flush_tok.kind        = KIND_IDENT;
                    flush_tok.table_index = sym_full ? '0 : IDX_W'(r_sym_cnt);
                    flush_tok.truncated   = r_ovf;
                    flush_tok.table_full  = sym_full;
                end
            end
            MODE_NUM: begin
                flush_tok.kind        = KIND_NUMBER;
                flush_tok.text        = r_buf;
                flush_tok.text_length = r_len;
                flush_tok.table_index = con_full ? '0 : IDX_W'(r_con_cnt);
                flush_tok.truncated   = r_ovf;
                flush_tok.table_full  = con_full;
            end
            MODE_LT: begin
                flush_tok.kind        = KIND_LT;
                flush_tok.text        = TEXT_W'(CH_LT);
                flush_tok.text_length = LEN_W'(1);
            end
            MODE_EQ: begin
                flush_tok.kind        = KIND_ASSIGN;
                flush_tok.text        = TEXT_W'(CH_EQ);
                flush_tok.text_length = LEN_W'(1);
            end
            default: flush_tok = '0;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_buf     = r_buf;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_sym_cnt = r_sym_cnt;
        n_con_cnt = r_con_cnt;
        do_flush  = 1'b0;
        do_start  = 1'b0;
        do_append = 1'b0;
        has_f     = 1'b0;
        has_s     = 1'b0;
        tok_f     = flush_tok;
        tok_s     = '0;

        if (i_eoi) begin
            do_flush = 1'b1;
        end else begin
            case (r_mode)
                MODE_WORD: begin
                    if (is_lower || is_digit) begin
                        do_append = 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit) begin
                        do_append = 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_LT, MODE_EQ: begin
                    if (i_ch == CH_EQ) begin
                        // two-character operator closes right here
                        has_f             = 1'b1;
                        tok_f             = '0;
                        tok_f.kind        = (r_mode == MODE_LT) ? KIND_LE : KIND_EQ;
                        tok_f.text        = TEXT_W'({CH_EQ, (r_mode == MODE_LT) ? CH_LT : CH_EQ});
                        tok_f.text_length = LEN_W'(2);
                        n_mode            = MODE_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        if (do_append) begin
            if (r_len < LEN_W'(MAX_LEXEME)) begin
                for (int b = 0; b < 8; b++) begin
                    if (r_len[2:0] == 3'(b)) begin
                        n_buf[8*b +: 8] = i_ch;
                    end
                end
                n_len = r_len + LEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (do_flush) begin
            has_f  = (r_mode != MODE_IDLE);
            n_mode = MODE_IDLE;
            n_buf  = '0;
            n_len  = '0;
            n_ovf  = 1'b0;
            if (r_mode == MODE_WORD && !kw.hit && !sym_full) begin
                n_sym_cnt = r_sym_cnt + CNT_W'(1);
            end
            if (r_mode == MODE_NUM && !con_full) begin
                n_con_cnt = r_con_cnt + CNT_W'(1);
            end
        end

        if (do_start) begin
            n_mode = MODE_IDLE;
            case (i_ch) inside
                [CH_LOWER_A:CH_LOWER_Z]: begin
                    n_mode = MODE_WORD;
                    n_buf  = TEXT_W'(i_ch);
                    n_len  = LEN_W'(1);
                end
                [CH_DIGIT_0:CH_DIGIT_9]: begin
                    n_mode = MODE_NUM;
                    n_buf  = TEXT_W'(i_ch);
                    n_len  = LEN_W'(1);
                end
                CH_SPACE, CH_IGNORE: ;
                CH_LT: n_mode = MODE_LT;
                CH_EQ: n_mode = MODE_EQ;
                default: begin
                    has_s             = 1'b1;
                    tok_s.text        = TEXT_W'(i_ch);
                    tok_s.text_length = LEN_W'(1);
                    case (i_ch)
                        CH_PLUS:  tok_s.kind = KIND_PLUS;
                        CH_MINUS: tok_s.kind = KIND_MINUS;
                        CH_STAR:  tok_s.kind = KIND_STAR;
                        CH_SEMI:  tok_s.kind = KIND_SEMI;
                        default:  tok_s.kind = KIND_ILLEGAL;
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        o_tok_a      = has_f ? tok_f : tok_s;
        o_tok_a.last = !(has_f && has_s);
        o_tok_b      = tok_s;
        o_tok_b.last = 1'b1;
        o_push_n     = {1'b0, has_f} + {1'b0, has_s};
    end

    assign o_stat = '{mode: r_mode, len: r_len, ovf: r_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_buf     <= '0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_sym_cnt <= '0;
            r_con_cnt <= '0;
        end else if (i_take) begin
            r_mode    <= n_mode;
            r_buf     <= n_buf;
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_sym_cnt <= n_sym_cnt;
            r_con_cnt <= n_con_cnt;
        end
    end

endmodule

FILE: design/kl_out_q.sv
module kl_out_q import kl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_tok       i_tok_a,
    input  t_tok       i_tok_b,
    input  logic       i_pop,
    output t_tok       o_head,
    output logic       o_valid,
    output logic [1:0] o_level
);

    // three-entry shift queue, head always in slot 0
    t_tok       r_q [3];
    t_tok       n_q [3];
    logic [1:0] r_level, n_level;
    logic [1:0] base;

    always_comb begin
        base = r_level - {1'b0, i_pop};
        for (int k = 0; k < 3; k++) begin
            n_q[k] = r_q[k];
        end
        if (i_pop) begin
            for (int k = 0; k < 2; k++) begin
                n_q[k] = r_q[k + 1];
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (i_push_n != 2'd0 && base == 2'(k)) begin
                n_q[k] = i_tok_a;
            end
            if (i_push_n == 2'd2 && base + 2'd1 == 2'(k)) begin
                n_q[k] = i_tok_b;
            end
        end
        n_level = base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_q[k] <= n_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_head  = r_q[0];
    assign o_valid = (r_level != 2'd0);
    assign o_level = r_level;

endmodule

FILE: design/keyword_lexer_core.sv
// Output: tokens from an accepted transaction are registered into the queue, whose head
//   drives the outputs; a second token follows once the first is taken.
// Throughput: one source character per cycle unless stalled; a character that closes
//   a pending token and emits its own puts two tokens in the queue, which stalls the input.
// Reset: synchronous active-low i_rst_n empties the queue, returns the scanner to idle
//   and clears the lexeme buffer and both table counters.
module keyword_lexer_core import kl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_LEXEME  = MAX_LEXEME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source character channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    // token channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic [2:0]  o_keyword_code,
    output logic [5:0]  o_table_index,
    output logic [63:0] o_text,
    output logic [3:0]  o_text_length,
    output logic        o_truncated,
    output logic        o_table_full,
    output logic        o_last
);

    // Scanner state and token build sit in kl_scan; tokens land in a small queue
    // whose head register drives the token channel directly.
    logic       in_take;
    logic       out_take;
    t_tok       tok_a, tok_b, head;
    logic [1:0] push_n;
    logic [1:0] level;
    t_scan_stat stat;

    // Every character may produce two tokens, so the queue must have two free
    // slots before a transaction is taken. Registered level keeps stall off the
    // downstream stall path.
    assign o_stall  = (level >= 2'd2);
    assign in_take  = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;

    kl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_LEXEME  (MAX_LEXEME)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (in_take),
        .i_ch     (i_ch),
        .i_eoi    (i_end_of_input),
        .o_tok_a  (tok_a),
        .o_tok_b  (tok_b),
        .o_push_n (push_n),
        .o_stat   (stat)
    );

    kl_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (in_take ? push_n : 2'd0),
        .i_tok_a  (tok_a),
        .i_tok_b  (tok_b),
        .i_pop    (out_take),
        .o_head   (head),
        .o_valid  (o_valid),
        .o_level  (level)
    );

    assign o_kind         = head.kind;
    assign o_keyword_code = head.keyword_code;
    assign o_table_index  = head.table_index;
    assign o_text         = head.text;
    assign o_text_length  = head.text_length;
    assign o_truncated    = head.truncated;
    assign o_table_full   = head.table_full;
    assign o_last         = head.last;

    // stall only ever comes from a queue that holds tokens
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty token queue");

    // buffered characters only exist while a word or number is pending
    a_len_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.len != 4'd0) |-> (stat.mode == MODE_WORD || stat.mode == MODE_NUM))
        else $error("lexeme buffer holds characters outside word or number");

    // overflow only after the buffer has filled
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.ovf |-> (stat.len == 4'(MAX_LEXEME)))
        else $error("lexeme overflow with buffer not full");

    // end of input always leaves the scanner idle
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_end_of_input) |=> (stat.mode == MODE_IDLE))
        else $error("scanner not idle after end of input");

endmodule
